// ===== rtl/m3i_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse pipeline.
// No dependencies; the modules and the testbench import this package.
`default_nettype none
package m3i_pkg;

  localparam int NEl     = 9;
  localparam int ThrW    = 31;
  localparam int DetW    = 98;   // signed Q48.48 determinant
  localparam int MagW    = 97;   // determinant magnitude
  localparam int QW      = 33;   // quotient bits before rounding
  localparam int DivStep = 33;   // one quotient bit per stage

  localparam logic [ThrW-1:0] THR_RESET = 31'd1;
  localparam logic signed [31:0] SAT_POS = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_NEG = 32'sh8000_0000;

  typedef logic signed [31:0] elem_t;
  typedef elem_t [NEl-1:0] mat_t;          // index = column*3 + row
  typedef logic signed [63:0] cof_t;
  typedef cof_t [NEl-1:0] cof_vec_t;
  typedef logic [63:0] mag64_t;
  typedef logic [3:0] idx_t;

  // Cofactor c[x][y] = m[A1]*m[A2] - m[B1]*m[B2], lanes in column*3 + row order
  localparam idx_t COF_A1 [NEl] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
  localparam idx_t COF_A2 [NEl] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
  localparam idx_t COF_B1 [NEl] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
  localparam idx_t COF_B2 [NEl] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

  typedef struct packed {
    mat_t     mat;
    cof_vec_t cof;
  } cof_pl_t;

  typedef struct packed {
    mat_t                mat;
    logic                sing;
    logic                dneg;
    logic [MagW-1:0]     dmag;
    logic [NEl-1:0]      cneg;
    mag64_t [NEl-1:0]    cm;
  } det_pl_t;

  typedef struct packed {
    logic [MagW-1:0] r;
    logic [QW-1:0]   q;
    logic            ovf;
    logic            neg;
    logic            cm0;
  } lane_t;

  typedef struct packed {
    mat_t             mat;
    logic             sing;
    logic [MagW-1:0]  den;
    lane_t [NEl-1:0]  lane;
  } div_st_t;

  typedef struct packed {
    mat_t res;
    logic sing;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/m3i_in_if.sv =====
// Input channel: one 3x3 matrix per transaction with valid/ready.
// No dependencies.
`default_nettype none
interface m3i_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] in_c0_r0, in_c0_r1, in_c0_r2;
  logic signed [31:0] in_c1_r0, in_c1_r1, in_c1_r2;
  logic signed [31:0] in_c2_r0, in_c2_r1, in_c2_r2;

  modport source (output valid, in_c0_r0, in_c0_r1, in_c0_r2, in_c1_r0, in_c1_r1,
                  in_c1_r2, in_c2_r0, in_c2_r1, in_c2_r2, input ready);
  modport sink (input valid, in_c0_r0, in_c0_r1, in_c0_r2, in_c1_r0, in_c1_r1,
                in_c1_r2, in_c2_r0, in_c2_r1, in_c2_r2, output ready);
endinterface
`default_nettype wire

// ===== rtl/m3i_out_if.sv =====
// Output channel: inverse matrix and singular flag per transaction.
// No dependencies.
`default_nettype none
interface m3i_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] out_c0_r0, out_c0_r1, out_c0_r2;
  logic signed [31:0] out_c1_r0, out_c1_r1, out_c1_r2;
  logic signed [31:0] out_c2_r0, out_c2_r1, out_c2_r2;
  logic singular;

  modport source (output valid, out_c0_r0, out_c0_r1, out_c0_r2, out_c1_r0, out_c1_r1,
                  out_c1_r2, out_c2_r0, out_c2_r1, out_c2_r2, singular, input ready);
  modport sink (input valid, out_c0_r0, out_c0_r1, out_c0_r2, out_c1_r0, out_c1_r1,
                out_c1_r2, out_c2_r0, out_c2_r1, out_c2_r2, singular, output ready);
endinterface
`default_nettype wire

// ===== rtl/m3i_cof.sv =====
// Cofactor stages: 18 element products, then the nine 2x2 cofactors.
// Depends on m3i_pkg.
`default_nettype none
module m3i_cof import m3i_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire mat_t    in_mat_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output cof_pl_t      out_data_o
);

  logic [1:0] v_q;
  logic       en0, en1;
  mat_t       mat1_q;
  cof_t       prod_a_q [NEl];
  cof_t       prod_b_q [NEl];
  cof_pl_t    out_q;

  // Advance a stage when it is empty or the next one moves
  assign en1 = !v_q[1] || out_ready_i;
  assign en0 = !v_q[0] || en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en0) v_q[0] <= in_valid_i;
      if (en1) v_q[1] <= v_q[0];
    end
  end

  // Form the products
  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      mat1_q <= in_mat_i;
      for (int i = 0; i < NEl; i++) begin
        prod_a_q[i] <= $signed(in_mat_i[COF_A1[i]]) * $signed(in_mat_i[COF_A2[i]]);
        prod_b_q[i] <= $signed(in_mat_i[COF_B1[i]]) * $signed(in_mat_i[COF_B2[i]]);
      end
    end
  end

  // Subtract, wrapping to 64 bits
  always_ff @(posedge clk_i) begin
    if (en1 && v_q[0]) begin
      out_q.mat <= mat1_q;
      for (int i = 0; i < NEl; i++) begin
        out_q.cof[i] <= prod_a_q[i] - prod_b_q[i];
      end
    end
  end

  assign in_ready_o  = en0;
  assign out_valid_o = v_q[1];
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/m3i_det.sv =====
// Determinant stages: first-column expansion, magnitude and singular test.
// Depends on m3i_pkg.
`default_nettype none
module m3i_det import m3i_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [ThrW-1:0] thr_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire cof_pl_t         in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output det_pl_t              out_data_o
);

  localparam int NSt = 5;

  logic [NSt-1:0] v_q;
  logic [NSt-1:0] v_in;
  logic [NSt:0]   en;
  cof_pl_t        p1_q, p2_q, p3_q;
  logic signed [63:0] ph_q [3];
  logic signed [64:0] pl_q [3];
  logic signed [DetW-1:0] term_q [3];
  logic signed [DetW-1:0] det_q;
  det_pl_t        d4_q, d5_q;
  det_pl_t        d5_d;
  logic [DetW-1:0] det_neg;

  // Ready chain from the output back to the input
  always_comb begin
    en[NSt] = out_ready_i;
    for (int k = NSt - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // Valid bit entering each stage
  assign v_in = {v_q[NSt-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NSt; k++) begin
        if (en[k]) v_q[k] <= v_in[k];
      end
    end
  end

  // Split each cofactor into halves so every multiply stays 32 bits wide
  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      p1_q <= in_data_i;
      for (int y = 0; y < 3; y++) begin
        ph_q[y] <= $signed(in_data_i.mat[y]) * $signed(in_data_i.cof[3*y][63:32]);
        pl_q[y] <= $signed(in_data_i.mat[y]) * $signed({1'b0, in_data_i.cof[3*y][31:0]});
      end
    end
  end

  // Recombine the halves of each term
  always_ff @(posedge clk_i) begin
    if (en[1] && v_q[0]) begin
      p2_q <= p1_q;
      for (int y = 0; y < 3; y++) begin
        term_q[y] <= $signed({{2{ph_q[y][63]}}, ph_q[y], 32'h0})
                   + $signed({{33{pl_q[y][64]}}, pl_q[y]});
      end
    end
  end

  // Sum the three terms
  always_ff @(posedge clk_i) begin
    if (en[2] && v_q[1]) begin
      p3_q  <= p2_q;
      det_q <= term_q[0] + term_q[1] + term_q[2];
    end
  end

  assign det_neg = -det_q;

  // Take magnitudes of the determinant and the cofactors
  always_ff @(posedge clk_i) begin
    if (en[3] && v_q[2]) begin
      d4_q.mat  <= p3_q.mat;
      d4_q.sing <= 1'b0;
      d4_q.dneg <= det_q[DetW-1];
      d4_q.dmag <= det_q[DetW-1] ? det_neg[MagW-1:0] : det_q[MagW-1:0];
      for (int i = 0; i < NEl; i++) begin
        d4_q.cneg[i] <= p3_q.cof[i][63];
        d4_q.cm[i]   <= p3_q.cof[i][63] ? 64'(64'h0 - p3_q.cof[i]) : 64'(p3_q.cof[i]);
      end
    end
  end

  // Compare against the threshold, zero determinant always singular
  always_comb begin
    d5_d      = d4_q;
    d5_d.sing = (d4_q.dmag < MagW'({thr_i, 32'h0})) || (d4_q.dmag == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en[4] && v_q[3]) begin
      d5_q <= d5_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NSt-1];
  assign out_data_o  = d5_q;

  a_nonsing_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] && !d5_q.sing |-> d5_q.dmag != '0)
    else $error("non-singular matrix with zero determinant");

endmodule
`default_nettype wire

// ===== rtl/m3i_div.sv =====
// Divider pipeline: nine lanes of restoring division, one quotient bit per
// stage, then rounding, saturation and the singular bypass. Depends on m3i_pkg.
`default_nettype none
module m3i_div import m3i_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire det_pl_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output res_t         out_data_o
);

  localparam int NSt  = DivStep + 2;  // setup, steps, finish
  localparam int Last = NSt - 1;

  logic [NSt-1:0] v_q;
  logic [NSt-1:0] v_in;
  logic [NSt:0]   en;
  div_st_t        st_q [DivStep+1];
  res_t           res_q;
  div_st_t        setup;

  function automatic lane_t div_step(input lane_t l, input logic [MagW-1:0] den,
                                     input logic b);
    logic [MagW:0] t;
    logic [MagW:0] d;
    lane_t         o;
    t = {l.r, b};
    d = {1'b0, den};
    o = l;
    if (t >= d) begin
      t   = t - d;
      o.q = {l.q[QW-2:0], 1'b1};
    end else begin
      o.q = {l.q[QW-2:0], 1'b0};
    end
    o.r = t[MagW-1:0];
    return o;
  endfunction

  function automatic elem_t finish(input lane_t l, input logic [MagW-1:0] den,
                                   input elem_t pass, input logic sing);
    logic          rnd;
    logic [QW:0]   qq;
    elem_t         v;
    rnd = {l.r, 1'b0} >= {1'b0, den};
    qq  = {1'b0, l.q} + (QW+1)'(rnd);
    if (sing) begin
      v = pass;
    end else if (l.neg) begin
      v = (l.ovf || qq > 34'h0_8000_0000) ? SAT_NEG : elem_t'(32'h0 - qq[31:0]);
    end else begin
      v = (l.ovf || qq > 34'h0_7FFF_FFFF) ? SAT_POS : elem_t'(qq[31:0]);
    end
    return v;
  endfunction

  // Ready chain from the output back to the input
  always_comb begin
    en[NSt] = out_ready_i;
    for (int k = NSt - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // Valid bit entering each stage
  assign v_in = {v_q[NSt-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NSt; k++) begin
        if (en[k]) v_q[k] <= v_in[k];
      end
    end
  end

  // Seed each lane with the numerator's top bits and flag quotient overflow
  always_comb begin
    setup.mat  = in_data_i.mat;
    setup.sing = in_data_i.sing;
    setup.den  = in_data_i.dmag;
    for (int i = 0; i < NEl; i++) begin
      setup.lane[i].r   = MagW'(in_data_i.cm[i][63:1]);
      setup.lane[i].q   = '0;
      setup.lane[i].ovf = MagW'(in_data_i.cm[i][63:1]) >= in_data_i.dmag;
      setup.lane[i].neg = in_data_i.cneg[i] ^ in_data_i.dneg;
      setup.lane[i].cm0 = in_data_i.cm[i][0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) st_q[0] <= setup;
  end

  // One quotient bit per stage; only the first step shifts in a cofactor bit, later steps shift in zeros
  for (genvar k = 1; k <= DivStep; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en[k] && v_q[k-1]) begin
        st_q[k].mat  <= st_q[k-1].mat;
        st_q[k].sing <= st_q[k-1].sing;
        st_q[k].den  <= st_q[k-1].den;
        for (int i = 0; i < NEl; i++) begin
          st_q[k].lane[i] <= div_step(st_q[k-1].lane[i], st_q[k-1].den,
                                      (k == 1) ? st_q[k-1].lane[i].cm0 : 1'b0);
        end
      end
    end
  end

  // Round, saturate, or pass the input through
  always_ff @(posedge clk_i) begin
    if (en[Last] && v_q[Last-1]) begin
      res_q.sing <= st_q[DivStep].sing;
      for (int i = 0; i < NEl; i++) begin
        res_q.res[i] <= finish(st_q[DivStep].lane[i], st_q[DivStep].den,
                               st_q[DivStep].mat[i], st_q[DivStep].sing);
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[Last];
  assign out_data_o  = res_q;

  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[17] && !en[18] |=> v_q[17])
    else $error("stalled stage dropped its transaction");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[20] && !st_q[20].sing && !st_q[20].lane[0].ovf
      |-> st_q[20].lane[0].r < st_q[20].den)
    else $error("division remainder not below divisor");

  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[Last] |-> in_ready_o)
    else $error("input blocked with empty output stage");

endmodule
`default_nettype wire

// ===== rtl/matrix3x3_inverse_top.sv =====
// An accepted transaction passes cofactor, determinant and divider stages
// (2 cofactor stages, 5 determinant stages, 35 divider stages).
// Throughput: one matrix per cycle unless stalled; 33 step stages set depth.
// Reset clears all stage valid bits and sets the singular threshold to 1.
// Depends on m3i_pkg, m3i_in_if, m3i_out_if, m3i_cof, m3i_det, m3i_div.
`default_nettype none
module matrix3x3_inverse_top import m3i_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [ThrW-1:0] cfg_wdata_i,
  m3i_in_if.sink               in_ch,
  m3i_out_if.source            out_ch
);

  logic [ThrW-1:0] thr_q;
  mat_t            in_mat;
  logic            cof_valid, cof_ready, det_valid, det_ready;
  cof_pl_t         cof_data;
  det_pl_t         det_data;
  res_t            res;

  // Hold the singular threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign in_mat[0] = in_ch.in_c0_r0;
  assign in_mat[1] = in_ch.in_c0_r1;
  assign in_mat[2] = in_ch.in_c0_r2;
  assign in_mat[3] = in_ch.in_c1_r0;
  assign in_mat[4] = in_ch.in_c1_r1;
  assign in_mat[5] = in_ch.in_c1_r2;
  assign in_mat[6] = in_ch.in_c2_r0;
  assign in_mat[7] = in_ch.in_c2_r1;
  assign in_mat[8] = in_ch.in_c2_r2;

  m3i_cof u_cof (
    .clk_i, .rst_ni,
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .in_mat_i    (in_mat),
    .out_valid_o (cof_valid),
    .out_ready_i (cof_ready),
    .out_data_o  (cof_data)
  );

  m3i_det u_det (
    .clk_i, .rst_ni,
    .thr_i       (thr_q),
    .in_valid_i  (cof_valid),
    .in_ready_o  (cof_ready),
    .in_data_i   (cof_data),
    .out_valid_o (det_valid),
    .out_ready_i (det_ready),
    .out_data_o  (det_data)
  );

  m3i_div u_div (
    .clk_i, .rst_ni,
    .in_valid_i  (det_valid),
    .in_ready_o  (det_ready),
    .in_data_i   (det_data),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_o  (res)
  );

  assign out_ch.out_c0_r0 = res.res[0];
  assign out_ch.out_c0_r1 = res.res[1];
  assign out_ch.out_c0_r2 = res.res[2];
  assign out_ch.out_c1_r0 = res.res[3];
  assign out_ch.out_c1_r1 = res.res[4];
  assign out_ch.out_c1_r2 = res.res[5];
  assign out_ch.out_c2_r0 = res.res[6];
  assign out_ch.out_c2_r1 = res.res[7];
  assign out_ch.out_c2_r2 = res.res[8];
  assign out_ch.singular  = res.sing;

endmodule
`default_nettype wire

// ===== sim/matrix3x3_inverse_top_tb.sv =====
// Testbench for matrix3x3_inverse_top: directed and random 3x3 matrices, checked
// against an in-bench Q16.16 adjugate inverse predictor under random idling.
// Depends on m3i_pkg, m3i_in_if, m3i_out_if and the RTL of the top level.
`default_nettype none
module matrix3x3_inverse_top_tb import m3i_pkg::*;;

  localparam int CycleLimit = 600000;
  localparam int Drain      = 60;

  // Element picks for random matrices
  typedef enum int {K_FULL, K_SMALL, K_TINY, K_EXTREME} elem_kind_e;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [ThrW-1:0] cfg_wdata_i;

  m3i_in_if  in_ch ();
  m3i_out_if out_ch ();

  matrix3x3_inverse_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  res_t            inverse_q[$];
  logic [ThrW-1:0] thr_model;
  int              send_idle_pct;
  int              recv_stall_pct;
  int              mismatches;
  int              sent;
  int              received;
  int              singular_seen;
  int              cycles;

  // Clock
  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // Predict one result: adjugate/determinant, rounded, saturated; m if singular
  function automatic res_t invert_q16(mat_t m, logic [ThrW-1:0] thr);
    logic signed [63:0]  e [NEl];
    logic signed [63:0]  cof [NEl];
    logic signed [127:0] det;
    logic [127:0]        dmag;
    logic [127:0]        lim;
    logic [127:0]        num;
    logic [127:0]        quo;
    logic [127:0]        rem;
    logic [63:0]         cm;
    logic                neg;
    res_t                r;
    for (int i = 0; i < NEl; i++) e[i] = m[i];
    cof[0] = e[4] * e[8] - e[7] * e[5];
    cof[3] = e[6] * e[5] - e[3] * e[8];
    cof[6] = e[3] * e[7] - e[6] * e[4];
    cof[1] = e[7] * e[2] - e[1] * e[8];
    cof[4] = e[0] * e[8] - e[6] * e[2];
    cof[7] = e[6] * e[1] - e[0] * e[7];
    cof[2] = e[1] * e[5] - e[4] * e[2];
    cof[5] = e[3] * e[2] - e[0] * e[5];
    cof[8] = e[0] * e[4] - e[3] * e[1];
    det = 128'(e[0]) * 128'(cof[0]) + 128'(e[1]) * 128'(cof[3])
        + 128'(e[2]) * 128'(cof[6]);
    dmag = det[127] ? -det : det;
    lim = {65'd0, thr, 32'd0};
    r.sing = (dmag < lim) || (dmag == 0);
    if (r.sing) begin
      r.res = m;
      return r;
    end
    for (int i = 0; i < NEl; i++) begin
      cm = cof[i][63] ? -cof[i] : cof[i];
      num = {32'd0, cm, 32'd0};
      quo = num / dmag;
      rem = num % dmag;
      if ((rem << 1) >= dmag) quo = quo + 1;
      neg = cof[i][63] ^ det[127];
      if (neg) begin
        r.res[i] = (quo > 128'h8000_0000) ? SAT_NEG : -quo[31:0];
      end else begin
        r.res[i] = (quo > 128'h7FFF_FFFF) ? SAT_POS : quo[31:0];
      end
    end
    return r;
  endfunction

  function automatic elem_t rand_elem(elem_kind_e kind);
    case (kind)
      K_FULL:  return $urandom;
      K_SMALL: return $signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
      K_TINY:  return $signed($urandom_range(0, 511)) - 256;
      default: begin
        case ($urandom_range(4))
          0: return SAT_POS;
          1: return SAT_NEG;
          2: return 32'sd1;
          3: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
    endcase
  endfunction

  // Mostly well-conditioned matrices, plus rank-deficient, tiny and wild ones
  function automatic mat_t rand_matrix();
    mat_t       m;
    elem_kind_e kind;
    int         pick;
    pick = $urandom_range(99);
    kind = (pick < 15) ? K_FULL : (pick < 60) ? K_SMALL : (pick < 80) ? K_TINY : K_EXTREME;
    for (int i = 0; i < NEl; i++) m[i] = rand_elem(kind);
    if ($urandom_range(9) == 0) begin
      // drop rank: third column is the sum of the first two
      for (int r = 0; r < 3; r++) m[6 + r] = m[r] + m[3 + r];
    end else if ($urandom_range(9) == 0) begin
      // strong diagonal over small noise
      for (int r = 0; r < 3; r++) m[r * 4] = rand_elem(K_SMALL) + 32'sh0004_0000;
    end
    return m;
  endfunction

  function automatic mat_t diag_matrix(elem_t a, elem_t b, elem_t c);
    mat_t m;
    m = '0;
    m[0] = a;
    m[4] = b;
    m[8] = c;
    return m;
  endfunction

  // Send one matrix and record its expected inverse on acceptance
  task automatic send_matrix(mat_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      @(posedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(posedge clk_i);
    in_ch.valid    <= 1'b1;
    in_ch.in_c0_r0 <= m[0];
    in_ch.in_c0_r1 <= m[1];
    in_ch.in_c0_r2 <= m[2];
    in_ch.in_c1_r0 <= m[3];
    in_ch.in_c1_r1 <= m[4];
    in_ch.in_c1_r2 <= m[5];
    in_ch.in_c2_r0 <= m[6];
    in_ch.in_c2_r1 <= m[7];
    in_ch.in_c2_r2 <= m[8];
    @(negedge clk_i);
    while (!in_ch.ready) @(negedge clk_i);
    inverse_q = {inverse_q, invert_q16(m, thr_model)};
    sent++;
  endtask

  task automatic release_input();
    @(posedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    release_input();
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  // Write the threshold with the pipeline empty
  task automatic set_threshold(logic [ThrW-1:0] thr);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    thr_model = thr;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Random matrices through each idling phase in turn
  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      case ((i * 5) / count)
        0: set_idling(0, 0);
        1: set_idling(80, 0);
        2: set_idling(0, 80);
        3: set_idling(32, 32);
        default: set_idling(0, 0);
      endcase
      send_matrix(rand_matrix());
    end
  endtask

  task automatic test_directed();
    mat_t m;
    set_idling(0, 0);
    send_matrix(diag_matrix(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
    send_matrix(diag_matrix(32'sh0002_0000, -32'sh0004_0000, 32'sh0000_8000));
    send_matrix(diag_matrix(32'sh0003_0000, 32'sh0003_0000, 32'sh0003_0000));
    send_matrix('0);
    send_matrix({NEl{SAT_POS}});
    send_matrix({NEl{SAT_NEG}});
    send_matrix(diag_matrix(SAT_NEG, SAT_NEG, SAT_NEG));
    send_matrix(diag_matrix(SAT_POS, SAT_NEG, SAT_POS));
    send_matrix(diag_matrix(32'sd1, 32'sd1, 32'sd1));
    send_matrix(diag_matrix(32'sd256, 32'sd256, 32'sd256));
    send_matrix(diag_matrix(32'sh0000_0100, 32'sh0100_0000, 32'sh0001_0000));
    send_matrix(diag_matrix(-32'sd1, -32'sd1, -32'sd1));
    // permutation, saturated diagonal and rank-deficient cases
    m = '0;
    m[1] = 32'sh0001_0000;
    m[3] = 32'sh0001_0000;
    m[8] = -32'sh0001_0000;
    send_matrix(m);
    for (int i = 0; i < NEl; i++) m[i] = 32'sh0001_0000 * (i + 1);
    send_matrix(m);
    for (int i = 0; i < NEl; i++) m[i] = (i % 4 == 0) ? SAT_POS : 32'sd0;
    send_matrix(m);
    for (int i = 0; i < NEl; i++) m[i] = (i % 2 == 0) ? SAT_NEG : SAT_POS;
    send_matrix(m);
    // small nonzero |det| values, all below the reset threshold
    send_matrix(diag_matrix(32'sh0000_0100, 32'sh0000_0100, 32'sd1));
    send_matrix(diag_matrix(32'sh0000_0100, 32'sh0000_0100, 32'sd2));
    send_matrix(diag_matrix(32'sh0000_0100, 32'sh0000_00FF, 32'sd1));
  endtask

  task automatic test_zero_threshold();
    set_threshold('0);
    send_matrix('0);
    send_matrix(diag_matrix(32'sd1, 32'sd1, 32'sd1));
    send_matrix(diag_matrix(32'sd1, -32'sd1, 32'sd2));
    send_matrix({NEl{SAT_NEG}});
    run_random(290);
  endtask

  task automatic test_max_threshold();
    set_threshold({ThrW{1'b1}});
    send_matrix(diag_matrix(SAT_POS, SAT_POS, SAT_POS));
    send_matrix(diag_matrix(SAT_NEG, SAT_NEG, SAT_NEG));
    run_random(290);
  endtask

  task automatic test_thresholds();
    set_threshold(31'h0001_0000);
    run_random(290);
    set_threshold(31'($urandom));
    run_random(290);
    set_threshold(THR_RESET);
    run_random(290);
  endtask

  // Receiver stalls
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each output transaction against the oldest expectation
  always @(negedge clk_i) begin
    res_t got;
    res_t want;
    logic bad;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.res  = {out_ch.out_c2_r2, out_ch.out_c2_r1, out_ch.out_c2_r0,
                  out_ch.out_c1_r2, out_ch.out_c1_r1, out_ch.out_c1_r0,
                  out_ch.out_c0_r2, out_ch.out_c0_r1, out_ch.out_c0_r0};
      got.sing = out_ch.singular;
      received++;
      if (inverse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        want = inverse_q.pop_front();
        bad  = (got.sing !== want.sing);
        for (int i = 0; i < NEl; i++) bad |= (got.res[i] !== want.res[i]);
        if (want.sing) singular_seen++;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at result %0d, cycle %0d", received, cycles);
            for (int i = 0; i < NEl; i++) begin
              $display("  c%0d_r%0d expected %h got %h", i / 3, i % 3,
                       want.res[i], got.res[i]);
            end
            $display("  singular expected %b got %b", want.sing, got.sing);
          end
        end
      end
    end
  end

  // Guard against a hang
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               inverse_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_ch.valid    = 1'b0;
    in_ch.in_c0_r0 = '0;
    in_ch.in_c0_r1 = '0;
    in_ch.in_c0_r2 = '0;
    in_ch.in_c1_r0 = '0;
    in_ch.in_c1_r1 = '0;
    in_ch.in_c1_r2 = '0;
    in_ch.in_c2_r0 = '0;
    in_ch.in_c2_r1 = '0;
    in_ch.in_c2_r2 = '0;
    out_ch.ready   = 1'b0;
    thr_model      = THR_RESET;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    sent           = 0;
    received       = 0;
    singular_seen  = 0;
    cycles         = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_zero_threshold();
    test_max_threshold();
    test_thresholds();
    wait_drained();

    $display("sent %0d matrices, checked %0d results (%0d singular pass-throughs)",
             sent, received, singular_seen);
    $display("thresholds covered: reset, zero, maximum, one, random; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/m3i_pkg.sv
rtl/m3i_in_if.sv
rtl/m3i_out_if.sv
rtl/m3i_cof.sv
rtl/m3i_det.sv
rtl/m3i_div.sv
rtl/matrix3x3_inverse_top.sv
sim/matrix3x3_inverse_top_tb.sv
